[design/hrhp_pkg.sv]
// Shared types and constants for the HTTP response header parser.
// Holds the header key text, line offsets, byte codes and the number-scanning step.
// No dependencies.
package hrhp_pkg;

    localparam int OFFSET_BITS = 5;

    localparam logic [OFFSET_BITS-1:0] CODE_FIRST = 5'd9;
    localparam logic [OFFSET_BITS-1:0] CODE_LAST  = 5'd11;
    localparam logic [OFFSET_BITS-1:0] KEY_LEN    = 5'd15;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = 5'd31;
    localparam logic [OFFSET_BITS-1:0] OFFSET_ONE = 5'd1;

    localparam int CODE_BITS = 10;

    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_PLUS  = 8'h2B;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;

    // "Content-Length:"
    localparam logic [7:0] KEY_TEXT [0:14] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
    };

    // Number scanner phases.
    localparam logic [1:0] PHASE_SKIP   = 2'd0;
    localparam logic [1:0] PHASE_DIGITS = 2'd1;
    localparam logic [1:0] PHASE_DONE   = 2'd3;

    typedef struct packed {
        logic       take;
        logic [3:0] digit;
        logic [1:0] phase;
    } num_step_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == BYTE_SPACE) || (b >= BYTE_TAB && b <= BYTE_CR);
    endfunction

    // One byte of an atoi-style scan: skip white space, an optional plus,
    // then digits until the first other byte.
    function automatic num_step_t number_step(input logic [1:0] phase,
                                              input logic [7:0] b);
        num_step_t  r;
        logic       is_digit;
        logic [7:0] diff;
        is_digit = (b >= BYTE_ZERO) && (b <= BYTE_NINE);
        diff     = b - BYTE_ZERO;
        r.take   = 1'b0;
        r.digit  = diff[3:0];
        r.phase  = phase;
        unique case (phase)
            PHASE_SKIP:
            begin
                if (is_space(b))
                begin
                    r.phase = PHASE_SKIP;
                end
                else if (b == BYTE_PLUS)
                begin
                    r.phase = PHASE_DIGITS;
                end
                else if (is_digit)
                begin
                    r.phase = PHASE_DIGITS;
                    r.take  = 1'b1;
                end
                else
                begin
                    r.phase = PHASE_DONE;
                end
            end
            PHASE_DIGITS:
            begin
                if (is_digit)
                begin
                    r.take = 1'b1;
                end
                else
                begin
                    r.phase = PHASE_DONE;
                end
            end
            default:
            begin
                r.phase = phase;
            end
        endcase
        return r;
    endfunction

endpackage

[design/http_response_header_parser.sv]
// A result is registered into the output buffer on the beat of the LF that
// ends the header. One header byte is taken per cycle while the skid entry is empty;
// each byte is scanned by one pass of compare and shift-add logic into the parser state.
// A two-entry output buffer lets bytes keep flowing while a result waits.
// Reset (rst_n, asynchronous, active low) clears the parser state and empties the buffer.
// Depends on hrhp_pkg.
module http_response_header_parser
    import hrhp_pkg::*;
#(
    parameter int LENGTH_BITS = 31
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             header_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CODE_BITS-1:0]   status_code,
    output logic [LENGTH_BITS-1:0] content_length,
    output logic                   length_saturated
);

    localparam int PROD_BITS = LENGTH_BITS + 4;
    localparam int CPROD_BITS = CODE_BITS + 4;

    typedef struct packed {
        logic [CODE_BITS-1:0]   code;
        logic [LENGTH_BITS-1:0] len;
        logic                   sat;
    } result_t;

    // Parser state.
    logic                   prev_cr_reg, prev_cr_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic                   first_line_reg, first_line_next;
    logic                   prefix_reg, prefix_next;
    logic [1:0]             phase_reg, phase_next;
    logic [CODE_BITS-1:0]   code_reg, code_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   clamped_reg, clamped_next;

    // Output buffer.
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    logic            accept;
    logic            emit;
    logic            pop;
    num_step_t       nstep;
    logic [PROD_BITS-1:0]  len_prod;
    logic [CPROD_BITS-1:0] code_prod;
    result_t         result;

    assign accept   = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;
    assign in_ready = !skid_valid_reg;

    assign nstep = number_step(phase_reg, header_byte);

    // Multiply by ten as two shifts and an add, then add the digit.
    assign len_prod = (PROD_BITS'(len_reg) << 3) + (PROD_BITS'(len_reg) << 1)
                    + PROD_BITS'(nstep.digit);
    assign code_prod = (CPROD_BITS'(code_reg) << 3) + (CPROD_BITS'(code_reg) << 1)
                     + CPROD_BITS'(nstep.digit);

    assign result.code = code_reg;
    assign result.len  = len_reg;
    assign result.sat  = clamped_reg;

    always_comb
    begin
        prev_cr_next    = prev_cr_reg;
        offset_next     = offset_reg;
        first_line_next = first_line_reg;
        prefix_next     = prefix_reg;
        phase_next      = phase_reg;
        code_next       = code_reg;
        len_next        = len_reg;
        clamped_next    = clamped_reg;
        emit            = 1'b0;

        if (first_line_reg)
        begin
            if (offset_reg >= CODE_FIRST && offset_reg <= CODE_LAST)
            begin
                phase_next = nstep.phase;
                if (nstep.take)
                begin
                    code_next = code_prod[CODE_BITS-1:0];
                end
            end
        end
        else if (offset_reg < KEY_LEN)
        begin
            if (header_byte != KEY_TEXT[offset_reg[3:0]])
            begin
                prefix_next = 1'b0;
            end
        end
        else if (prefix_reg)
        begin
            if (offset_reg == KEY_LEN)
            begin
                // A new Content-Length line replaces any earlier value.
                len_next     = '0;
                clamped_next = 1'b0;
            end
            else
            begin
                phase_next = nstep.phase;
                if (nstep.take)
                begin
                    if (|len_prod[PROD_BITS-1:LENGTH_BITS])
                    begin
                        len_next     = '1;
                        clamped_next = 1'b1;
                    end
                    else
                    begin
                        len_next = len_prod[LENGTH_BITS-1:0];
                    end
                end
            end
        end

        if (prev_cr_reg && header_byte == BYTE_LF)
        begin
            if (offset_reg == OFFSET_ONE)
            begin
                // An empty line ends the header: report and start over.
                emit            = 1'b1;
                first_line_next = 1'b1;
                code_next       = '0;
                len_next        = '0;
                clamped_next    = 1'b0;
            end
            else
            begin
                first_line_next = 1'b0;
            end
            offset_next = '0;
            prefix_next = 1'b1;
            phase_next  = PHASE_SKIP;
            prev_cr_next = 1'b0;
        end
        else
        begin
            prev_cr_next = (header_byte == BYTE_CR);
            if (offset_reg < OFFSET_MAX)
            begin
                offset_next = offset_reg + OFFSET_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cr_reg    <= 1'b0;
            offset_reg     <= '0;
            first_line_reg <= 1'b1;
            prefix_reg     <= 1'b1;
            phase_reg      <= PHASE_SKIP;
            code_reg       <= '0;
            len_reg        <= '0;
            clamped_reg    <= 1'b0;
        end
        else if (accept)
        begin
            prev_cr_reg    <= prev_cr_next;
            offset_reg     <= offset_next;
            first_line_reg <= first_line_next;
            prefix_reg     <= prefix_next;
            phase_reg      <= phase_next;
            code_reg       <= code_next;
            len_reg        <= len_next;
            clamped_reg    <= clamped_next;
        end
    end

    // The skid entry only fills when the output entry is held by the consumer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && emit)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept && emit)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= result;
            end
            else
            begin
                out_data_reg <= result;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign status_code      = out_data_reg.code;
    assign content_length   = out_data_reg.len;
    assign length_saturated = out_data_reg.sat;

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output entry empty");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        code_reg <= CODE_BITS'(999))
        else $error("status code exceeds three decimal digits");

    a_sat_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.sat |-> &out_data_reg.len)
        else $error("saturated length is not the field maximum");

    a_line_start_no_cr: assert property (@(posedge clk) disable iff (!rst_n)
        (offset_reg == '0) |-> !prev_cr_reg)
        else $error("CR flag set at start of a line");
`endif

endmodule

[tb/hrhp_checker.sv]
// Checker for the HTTP response header parser: watches both channels, predicts
// the parsed header summary from the accepted bytes and compares it with each result.
// Depends on hrhp_pkg.
module hrhp_checker
    import hrhp_pkg::*;
#(
    parameter int LENGTH_BITS = 31
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [7:0]             header_byte,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [CODE_BITS-1:0]   status_code,
    input  logic [LENGTH_BITS-1:0] content_length,
    input  logic                   length_saturated,
    output int                     errors,
    output int                     outstanding,
    output int                     headers_done,
    output int                     bytes_taken,
    output int                     clamped_headers
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CODE_BITS-1:0]   code;
        logic [LENGTH_BITS-1:0] length;
        logic                   sat;
    } header_summary_t;

    localparam logic [63:0] LENGTH_CEIL = (64'd1 << LENGTH_BITS) - 64'd1;

    // Predicted parser state.
    logic                 prev_cr;
    logic [4:0]           offset;
    logic                 first_line;
    logic                 key_match;
    logic [1:0]           scan_phase;
    logic [CODE_BITS-1:0] code_acc;
    logic [63:0]          length_acc;
    logic                 clamp;

    header_summary_t summary_q[$];

    task automatic clear_parser();
        prev_cr    = 1'b0;
        offset     = '0;
        first_line = 1'b1;
        key_match  = 1'b1;
        scan_phase = PHASE_SKIP;
        code_acc   = '0;
        length_acc = '0;
        clamp      = 1'b0;
    endtask

    // atoi-style scan of one byte: blanks, then an optional plus, then digits.
    task automatic scan_number(input logic [7:0] b, output logic take, output logic [3:0] digit);
        logic       is_digit;
        logic       blank;
        logic [7:0] diff;
        is_digit = (b >= BYTE_ZERO) && (b <= BYTE_NINE);
        blank    = (b == BYTE_SPACE) || (b >= BYTE_TAB && b <= BYTE_CR);
        diff     = b - BYTE_ZERO;
        digit    = diff[3:0];
        take     = 1'b0;
        case (scan_phase)
            PHASE_SKIP:
            begin
                if (!blank)
                begin
                    if (b == BYTE_PLUS)
                    begin
                        scan_phase = PHASE_DIGITS;
                    end
                    else if (is_digit)
                    begin
                        scan_phase = PHASE_DIGITS;
                        take       = 1'b1;
                    end
                    else
                    begin
                        scan_phase = PHASE_DONE;
                    end
                end
            end
            PHASE_DIGITS:
            begin
                if (is_digit)
                begin
                    take = 1'b1;
                end
                else
                begin
                    scan_phase = PHASE_DONE;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic parse_byte(input logic [7:0] b, output logic emit, output header_summary_t res);
        logic       take;
        logic [3:0] digit;
        logic [4:0] off;
        off  = offset;
        emit = 1'b0;
        res  = '0;
        if (first_line)
        begin
            if (off >= CODE_FIRST && off <= CODE_LAST)
            begin
                scan_number(b, take, digit);
                if (take)
                begin
                    code_acc = CODE_BITS'(code_acc * 10 + digit);
                end
            end
        end
        else if (off < KEY_LEN)
        begin
            if (b != KEY_TEXT[off[3:0]])
            begin
                key_match = 1'b0;
            end
        end
        else if (key_match)
        begin
            // The byte right after the colon is skipped but restarts the value.
            if (off == KEY_LEN)
            begin
                length_acc = '0;
                clamp      = 1'b0;
            end
            else
            begin
                scan_number(b, take, digit);
                if (take)
                begin
                    if (length_acc > (LENGTH_CEIL - 64'(digit)) / 64'd10)
                    begin
                        length_acc = LENGTH_CEIL;
                        clamp      = 1'b1;
                    end
                    else
                    begin
                        length_acc = length_acc * 64'd10 + 64'(digit);
                    end
                end
            end
        end

        if (prev_cr && b == BYTE_LF)
        begin
            if (off == OFFSET_ONE)
            begin
                emit       = 1'b1;
                res.code   = code_acc;
                res.length = length_acc[LENGTH_BITS-1:0];
                res.sat    = clamp;
                clear_parser();
            end
            else
            begin
                first_line = 1'b0;
                offset     = '0;
                key_match  = 1'b1;
                scan_phase = PHASE_SKIP;
                prev_cr    = 1'b0;
            end
        end
        else
        begin
            prev_cr = (b == BYTE_CR);
            if (off < OFFSET_MAX)
            begin
                offset = off + 5'd1;
            end
        end
    endtask

    task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic            emit;
        header_summary_t predicted;
        header_summary_t want;
        if (!rst_n)
        begin
            clear_parser();
            summary_q.delete();
            errors          = 0;
            headers_done    = 0;
            bytes_taken     = 0;
            clamped_headers = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (summary_q.size() == 0)
                begin
                    errors++;
                    $display({"%0t: unexpected result beat: expected none, ",
                              "actual code %0d length %0d saturated %0b"},
                             $time, status_code, content_length, length_saturated);
                end
                else
                begin
                    want = summary_q.pop_front();
                    report_field("status_code", 64'(want.code), 64'(status_code));
                    report_field("content_length", 64'(want.length), 64'(content_length));
                    report_field("length_saturated", 64'(want.sat), 64'(length_saturated));
                    headers_done++;
                    if (want.sat)
                    begin
                        clamped_headers++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                bytes_taken++;
                parse_byte(header_byte, emit, predicted);
                if (emit)
                begin
                    summary_q.push_back(predicted);
                end
            end
        end
        outstanding = summary_q.size();
    end

endmodule

[tb/tb_top.sv]
// Top of the HTTP response header parser testbench: clock, reset, byte stimulus,
// result back-pressure, a stall watchdog and the verdict.
// Depends on hrhp_pkg, http_response_header_parser and hrhp_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hrhp_pkg::*;

    localparam int LENGTH_BITS = 31;
    // Cycles without any beat before the run is called hung. Even the 67 percent
    // idle settings never come near this in a correct run.
    localparam int STALL_LIMIT = 2000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             header_byte = 8'h00;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [CODE_BITS-1:0]   status_code;
    logic [LENGTH_BITS-1:0] content_length;
    logic                   length_saturated;

    int errors;
    int outstanding;
    int headers_done;
    int bytes_taken;
    int clamped_headers;

    int send_idle_pct = 15;
    int recv_idle_pct = 67;
    int stall_cycles  = 0;

    logic [7:0] byte_q[$];

    http_response_header_parser #(.LENGTH_BITS(LENGTH_BITS)) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .header_byte      (header_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status_code      (status_code),
        .content_length   (content_length),
        .length_saturated (length_saturated)
    );

    hrhp_checker #(.LENGTH_BITS(LENGTH_BITS)) header_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .header_byte      (header_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status_code      (status_code),
        .content_length   (content_length),
        .length_saturated (length_saturated),
        .errors           (errors),
        .outstanding      (outstanding),
        .headers_done     (headers_done),
        .bytes_taken      (bytes_taken),
        .clamped_headers  (clamped_headers)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat on either channel for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            byte_q.push_back(s[i]);
        end
    endtask

    task automatic put_line(string s);
        put_text(s);
        byte_q.push_back(BYTE_CR);
        byte_q.push_back(BYTE_LF);
    endtask

    task automatic put_printable(int count);
        repeat (count)
        begin
            byte_q.push_back(8'($urandom_range(32, 126)));
        end
    endtask

    // Sends every queued byte; each call returns at the edge where the last beat was taken.
    task automatic send_queue();
        logic [7:0] b;
        while (byte_q.size() != 0)
        begin
            b = byte_q.pop_front();
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid    <= 1'b1;
            header_byte <= b;
            @(posedge clk);
            while (!in_ready)
            begin
                @(posedge clk);
            end
        end
    endtask

    // Holds the sender off until every predicted result has been taken.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic build_random_header();
        int    r;
        int    n;
        string key;
        if ($urandom_range(99) < 8)
        begin
            // Raw noise, heavy in CR and LF, sometimes closed by a blank line.
            n = $urandom_range(1, 30);
            repeat (n)
            begin
                if ($urandom_range(3) == 0)
                begin
                    byte_q.push_back($urandom_range(1) ? BYTE_CR : BYTE_LF);
                end
                else
                begin
                    byte_q.push_back(8'($urandom_range(255)));
                end
            end
            if ($urandom_range(1))
            begin
                put_line("");
                put_line("");
            end
        end
        else
        begin
            if ($urandom_range(9) == 0)
            begin
                put_printable($urandom_range(0, 8));
            end
            else
            begin
                put_text("HTTP/1.1 ");
                repeat (3)
                begin
                    r = $urandom_range(99);
                    if (r < 70)
                        byte_q.push_back(8'(BYTE_ZERO + $urandom_range(9)));
                    else if (r < 78)
                        byte_q.push_back(BYTE_SPACE);
                    else if (r < 84)
                        byte_q.push_back(BYTE_PLUS);
                    else if (r < 90)
                        put_text("-");
                    else
                        byte_q.push_back(8'($urandom_range(255)));
                end
                put_printable($urandom_range(0, 12));
            end
            put_line("");
            repeat ($urandom_range(0, 3))
            begin
                r = $urandom_range(99);
                if (r < 45)
                begin
                    put_text("Content-Length:");
                    byte_q.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                              : BYTE_SPACE);
                    repeat ($urandom_range(0, 3))
                    begin
                        byte_q.push_back($urandom_range(1) ? BYTE_SPACE : BYTE_TAB);
                    end
                    r = $urandom_range(9);
                    if (r == 0)
                        put_text("+");
                    else if (r == 1)
                        put_text("-");
                    // Now and then enough digits to pass the top of the field.
                    n = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
                    repeat (n)
                    begin
                        byte_q.push_back(8'(BYTE_ZERO + $urandom_range(9)));
                    end
                    if ($urandom_range(3) == 0)
                        put_printable($urandom_range(1, 4));
                end
                else if (r < 60)
                begin
                    key = "Content-Length:";
                    key[$urandom_range(14)] = 8'($urandom_range(1, 255));
                    put_text(key);
                    put_text(" 42");
                end
                else if (r < 85)
                begin
                    put_printable($urandom_range(0, 20));
                end
                else
                begin
                    repeat ($urandom_range(0, 40))
                    begin
                        byte_q.push_back(8'($urandom_range(255)));
                    end
                end
                put_line("");
            end
            put_line("");
        end
    endtask

    initial
    begin
        int phase_bytes;
        int phase_headers;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed headers: bare header, plain codes, signs and blanks in the code,
        // short first line, limits of the length field, clamping, override,
        // empty and negative lengths, the ignored byte after the colon,
        // lookalike keys, long lines, stray CR and LF, and extreme byte values.
        put_line("");
        put_line("HTTP/1.1 200 OK");
        put_line("");
        put_line("HTTP/1.1 404 Not Found");
        put_line("Content-Length: 1234");
        put_line("");
        put_line("HTTP/1");
        put_line("Content-Length: 0");
        put_line("");
        put_line("HTTP/1.1 -12 Bad");
        put_line("");
        put_line("HTTP/1.1 +42");
        put_line("Content-Length: +17");
        put_line("");
        put_line("HTTP/1.1 \t9x");
        put_line("Content-Length:  -5");
        put_line("");
        put_line("HTTP/1.1 999 Max");
        put_line("Content-Length: 2147483647");
        put_line("");
        put_line("HTTP/1.1 000");
        put_line("Content-Length: 2147483648");
        put_line("");
        put_line("HTTP/1.1 201");
        put_line("Content-Length: 99999999999999999999");
        put_line("Content-Length: 5");
        put_line("");
        put_line("HTTP/1.1 302");
        put_line("Content-Length: 77");
        put_line("content-length: 8");
        put_line("Content-Length:");
        put_line("");
        put_line("HTTP/1.1 100");
        put_line("Content-Length:7 3");
        put_line("Content-Length:                    12");
        put_line("");
        put_text("HTTP/1.1 500 xxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxx");
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        put_line("");
        put_text("X-A: a");
        byte_q.push_back(BYTE_CR);
        put_text("b");
        byte_q.push_back(BYTE_LF);
        put_line("c");
        byte_q.push_back(BYTE_CR);
        put_line("");
        put_line("");
        send_queue();
        drain();

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 67 : 0;
            recv_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 15 : 0;
            phase_bytes   = 0;
            phase_headers = 0;
            while (phase_bytes < 220 || phase_headers < 4)
            begin
                build_random_header();
                phase_bytes += byte_q.size();
                phase_headers++;
                send_queue();
                if ($urandom_range(9) == 0)
                begin
                    drain();
                end
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Parsed %0d header bytes into %0d headers (%0d with a clamped length),",
                 bytes_taken, headers_done, clamped_headers);
        $display("with stalls on the byte side, on the result side, and with none.");
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[http_response_header_parser.f]
design/hrhp_pkg.sv
design/http_response_header_parser.sv
tb/hrhp_checker.sv
tb/tb_top.sv
